[design/wsg_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsg_pkg
// Shared types, constants and wave tables of the waveform sample generator.
// ----------------------------------------------------------------------------
package wsg_pkg;

    localparam int SAMPLE_W        = 12;
    localparam int DIVISOR_W       = 9;
    localparam int VELOCITY_W      = 8;
    localparam int OFFSET_W        = 8;
    localparam int DAC_W           = 16;
    localparam int CFG_IDX_W       = 1;
    localparam int CFG_DATA_W      = 8;
    localparam int S_TDATA_W       = 8;
    localparam int M_TDATA_W       = 32;
    localparam int RAMP_STEPS_DEF  = 16;
    localparam int TABLE_DEPTH     = 16;
    localparam int TABLE_IDX_W     = 4;

    localparam logic [SAMPLE_W-1:0]   FULL_SCALE   = 12'hFFF;
    localparam logic [3:0]            DAC_CTRL     = 4'h7;
    localparam logic [VELOCITY_W-1:0] VELOCITY_RST = 8'd1;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_WAVE_SELECT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_VELOCITY    = 1'b1;

    // Event kinds carried on the input tuser bit.
    localparam logic EVT_SAMPLE   = 1'b0;
    localparam logic EVT_DUTY_END = 1'b1;

    typedef enum logic [1:0] {
        WAVE_SQUARE   = 2'd0,
        WAVE_SAWTOOTH = 2'd1,
        WAVE_SINE     = 2'd2,
        WAVE_TRIANGLE = 2'd3
    } t_wave;

    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_DIV  = 2'd1,
        S_PUT  = 2'd2
    } t_state;

    typedef struct packed {
        logic load;
        logic step;
        logic put;
    } t_dp_cmd;

    typedef struct packed {
        logic div_last;
        logic out_free;
    } t_dp_status;

    localparam logic [SAMPLE_W-1:0] SINE_TABLE [TABLE_DEPTH] = '{
        12'd2048, 12'd2832, 12'd3496, 12'd3940, 12'd4095, 12'd3940, 12'd3496, 12'd2832,
        12'd2048, 12'd1264, 12'd600,  12'd156,  12'd0,    12'd156,  12'd600,  12'd1264
    };

    localparam logic [SAMPLE_W-1:0] TRIANGLE_TABLE [TABLE_DEPTH] = '{
        12'd0,    12'd512,  12'd1024, 12'd1536, 12'd2048, 12'd2560, 12'd3072, 12'd3584,
        12'd4095, 12'd3584, 12'd3072, 12'd2560, 12'd2049, 12'd1536, 12'd1025, 12'd512
    };

endpackage

[design/wsg_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsg_ctrl
// Sequencer: accepts one event, runs the divider for a sample tick and hands the result over.
// ----------------------------------------------------------------------------
module wsg_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_tvalid,
    input  logic                i_kind,
    input  wsg_pkg::t_dp_status i_status,
    output logic                o_s_tready,
    output wsg_pkg::t_dp_cmd    o_cmd
);
    import wsg_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    n_state = (i_kind == EVT_DUTY_END) ? S_PUT : S_DIV;
                end
            end
            S_DIV: begin
                if (i_status.div_last) begin
                    n_state = S_PUT;
                end
            end
            S_PUT: begin
                if (i_status.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_s_tready = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            S_IDLE: begin
                o_s_tready = 1'b1;
                o_cmd.load = i_s_tvalid;
            end
            S_DIV: begin
                o_cmd.step = 1'b1;
            end
            S_PUT: begin
                o_cmd.put = i_status.out_free;
            end
            default: begin
                o_s_tready = 1'b0;
            end
        endcase
    end

`ifndef SYNTH
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("input accepted again while an event is in progress");

    a_div_ends_in_put: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV && i_status.div_last) |=> (r_state == S_PUT))
        else $error("divider finished but result was not handed over");

    a_put_returns_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.put |=> o_s_tready)
        else $error("not ready for the next event after a result was stored");
`endif

endmodule

[design/wsg_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsg_datapath
// Configuration, wave counters and tables, serial divider and output register.
// ----------------------------------------------------------------------------
module wsg_datapath #(
    parameter int RAMP_STEPS = wsg_pkg::RAMP_STEPS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [wsg_pkg::CFG_IDX_W-1:0]   i_cfg_addr,
    input  logic [wsg_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                            i_kind,
    input  logic [wsg_pkg::OFFSET_W-1:0]    i_offset,
    input  wsg_pkg::t_dp_cmd                i_cmd,
    input  logic                            i_m_tready,
    output wsg_pkg::t_dp_status             o_status,
    output logic                            o_m_tvalid,
    output logic [wsg_pkg::M_TDATA_W-1:0]   o_m_tdata
);
    import wsg_pkg::*;

    localparam int DIV_STEPS = SAMPLE_W;
    localparam int CNT_W     = $clog2(DIV_STEPS);
    localparam logic [SAMPLE_W-1:0] RAMP_STEP = SAMPLE_W'(4096 / RAMP_STEPS);
    localparam logic [CNT_W-1:0]    CNT_LAST  = CNT_W'(DIV_STEPS - 1);

    t_wave                   r_wave;
    logic [VELOCITY_W-1:0]   r_velocity;
    logic [SAMPLE_W-1:0]     r_ramp;
    logic [TABLE_IDX_W-1:0]  r_sine_idx;
    logic [TABLE_IDX_W-1:0]  r_tri_idx;
    logic [SAMPLE_W-1:0]     r_quo;
    logic [DIVISOR_W-1:0]    r_rem;
    logic [DIVISOR_W-1:0]    r_div;
    logic [CNT_W-1:0]        r_cnt;
    logic                    r_out_valid;
    logic [M_TDATA_W-1:0]    r_out_data;

    logic [SAMPLE_W-1:0]     n_ramp;
    logic [SAMPLE_W:0]       ramp_sum;
    logic [SAMPLE_W-1:0]     raw;
    logic [DIVISOR_W:0]      trial;
    logic [DIVISOR_W:0]      trial_diff;
    logic                    q_bit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wave     <= WAVE_SQUARE;
            r_velocity <= VELOCITY_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_WAVE_SELECT: r_wave     <= t_wave'(i_cfg_data[1:0]);
                CFG_VELOCITY:    r_velocity <= i_cfg_data[VELOCITY_W-1:0];
                default:         r_wave     <= r_wave;
            endcase
        end
    end

    // Sawtooth climbs, clips at full scale and falls to zero on the next tick.
    always_comb begin
        ramp_sum = {1'b0, r_ramp} + {1'b0, RAMP_STEP};
        if (r_ramp == FULL_SCALE) begin
            n_ramp = '0;
        end else if (ramp_sum[SAMPLE_W]) begin
            n_ramp = FULL_SCALE;
        end else begin
            n_ramp = ramp_sum[SAMPLE_W-1:0];
        end
    end

    always_comb begin
        unique case (r_wave)
            WAVE_SQUARE:   raw = FULL_SCALE;
            WAVE_SAWTOOTH: raw = n_ramp;
            WAVE_SINE:     raw = SINE_TABLE[r_sine_idx];
            WAVE_TRIANGLE: raw = TRIANGLE_TABLE[r_tri_idx];
            default:       raw = FULL_SCALE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ramp     <= '0;
            r_sine_idx <= '0;
            r_tri_idx  <= '0;
        end else if (i_cmd.load && i_kind == EVT_SAMPLE) begin
            case (r_wave)
                WAVE_SAWTOOTH: r_ramp     <= n_ramp;
                WAVE_SINE:     r_sine_idx <= r_sine_idx + 1'b1;
                WAVE_TRIANGLE: r_tri_idx  <= r_tri_idx + 1'b1;
                default:       r_ramp     <= r_ramp;
            endcase
        end
    end

    // Restoring division, one quotient bit per cycle. A zero divisor makes
    // every trial subtraction succeed, so the quotient saturates at all ones.
    always_comb begin
        trial      = {r_rem, r_quo[SAMPLE_W-1]};
        trial_diff = trial - {1'b0, r_div};
        q_bit      = (trial >= {1'b0, r_div});
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_quo <= (i_kind == EVT_DUTY_END) ? '0 : raw;
            r_rem <= '0;
            r_div <= {1'b0, r_velocity} + {1'b0, i_offset};
            r_cnt <= '0;
        end else if (i_cmd.step) begin
            r_quo <= {r_quo[SAMPLE_W-2:0], q_bit};
            r_rem <= q_bit ? trial_diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
            r_cnt <= r_cnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.put) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.put) begin
            r_out_data <= {4'h0, r_quo, DAC_CTRL, r_quo};
        end
    end

    assign o_status.div_last = (r_cnt == CNT_LAST);
    assign o_status.out_free = !r_out_valid || i_m_tready;
    assign o_m_tvalid        = r_out_valid;
    assign o_m_tdata         = r_out_data;

`ifndef SYNTH
    a_sine_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.load && i_kind == EVT_SAMPLE && r_wave == WAVE_SINE)
        |=> (r_sine_idx == $past(r_sine_idx) + 1'b1))
        else $error("sine index did not advance on a sine sample tick");

    a_duty_end_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.load && i_kind == EVT_DUTY_END) |=> (r_quo == '0))
        else $error("duty end did not clear the sample");

    a_put_shows_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.put |=> (o_m_tvalid && o_m_tdata[DAC_W-1:SAMPLE_W] == DAC_CTRL))
        else $error("stored result lacks the DAC control nibble");
`endif

endmodule

[design/waveform_sample_generator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// waveform_sample_generator
// Timer-event driven DAC sample generator for square, sawtooth, sine and
// triangle waves with amplitude scaling by division.
// ----------------------------------------------------------------------------
// Usage. Each input beat is one timer event: tuser says whether it is a sample
// tick or a duty end, and tdata carries the envelope offset for that tick.
// Every input beat produces exactly one output beat holding the 16-bit DAC
// command word and the scaled 12-bit sample.
// A sample tick takes the next raw sample of the selected wave, divides it by
// the velocity divisor plus the envelope offset and reports the quotient.
// The division is restoring and bit-serial, one quotient bit per cycle, so
// a sample tick passes through the accept, the divide steps and the store of
// the result before the block is ready again. The output beat is valid in
// the cycle after that store. A duty end skips the divider and goes from the
// accept straight to the store. One event is worked on at a time.
// The result sits in an output register, so the next event may be accepted
// while the previous beat still waits for the receiver. If the receiver
// stalls longer, the result waits in the quotient register and the sequencer
// holds its store state until the output register frees up; no beat is dropped.
// Configuration writes take effect at once and are meant to happen while the
// block is idle. Reset selects the square wave, sets the velocity divisor to
// one, clears the three wave counters and empties the output register.
// ----------------------------------------------------------------------------
module waveform_sample_generator #(
    parameter int RAMP_STEPS = wsg_pkg::RAMP_STEPS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Configuration write port.
    input  logic                            i_cfg_we,
    input  logic [wsg_pkg::CFG_IDX_W-1:0]   i_cfg_addr,
    input  logic [wsg_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    // Event input.
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [wsg_pkg::S_TDATA_W-1:0]   s_axis_tdata,  // [7:0] envelope_offset
    input  logic                            s_axis_tuser,  // [0] event_kind
    // Sample output.
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [wsg_pkg::M_TDATA_W-1:0]   m_axis_tdata   // [15:0] dac_word,
                                                           // [27:16] sample_value,
                                                           // [31:28] zero
);
    import wsg_pkg::*;

    t_dp_cmd    cmd;
    t_dp_status status;

    wsg_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .i_kind     (s_axis_tuser),
        .i_status   (status),
        .o_s_tready (s_axis_tready),
        .o_cmd      (cmd)
    );

    wsg_datapath #(
        .RAMP_STEPS (RAMP_STEPS)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_data (i_cfg_data),
        .i_kind     (s_axis_tuser),
        .i_offset   (s_axis_tdata[OFFSET_W-1:0]),
        .i_cmd      (cmd),
        .i_m_tready (m_axis_tready),
        .o_status   (status),
        .o_m_tvalid (m_axis_tvalid),
        .o_m_tdata  (m_axis_tdata)
    );

endmodule

[dv/waveform_sample_generator_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// waveform_sample_generator_tb
// Self-checking stream testbench for the waveform sample generator.
// ----------------------------------------------------------------------------
// Timer events are pushed into the slave stream and every DAC beat on the
// master stream is checked against a behavioural predictor. The predictor
// keeps its own wave selection, velocity divisor, sawtooth level and table
// positions. A short directed run walks the extremes (full-scale square,
// the complete sawtooth climb with saturation and fall back to zero, a zero
// divisor and the largest divisor, duty ends on the square and the sine). Random
// segments then follow under four handshake regimes, each segment starting
// from a fresh register setting written while the block is idle.
// ----------------------------------------------------------------------------
module waveform_sample_generator_tb;

    import wsg_pkg::*;

    localparam int CLK_HALF      = 5;
    localparam int RESET_CYCLES  = 8;
    localparam int RANDOM_PHASES = 4;
    localparam int PHASE_EVENTS  = 500;
    localparam int SEGMENT_SIZE  = 50;
    localparam int SETTLE_CYCLES = 20;
    localparam int RAMP_INC      = 4096 / RAMP_STEPS_DEF;

    // Our own copies of the two wave tables.
    localparam logic [SAMPLE_W-1:0] SINE_LUT [TABLE_DEPTH] = '{
        12'd2048, 12'd2832, 12'd3496, 12'd3940, 12'd4095, 12'd3940, 12'd3496, 12'd2832,
        12'd2048, 12'd1264, 12'd600,  12'd156,  12'd0,    12'd156,  12'd600,  12'd1264
    };
    localparam logic [SAMPLE_W-1:0] TRI_LUT [TABLE_DEPTH] = '{
        12'd0,    12'd512,  12'd1024, 12'd1536, 12'd2048, 12'd2560, 12'd3072, 12'd3584,
        12'd4095, 12'd3584, 12'd3072, 12'd2560, 12'd2049, 12'd1536, 12'd1025, 12'd512
    };

    typedef struct packed {
        logic [DAC_W-1:0]    dac;
        logic [SAMPLE_W-1:0] scaled;
    } t_dac_beat;

    // Predicts the DAC beat of every accepted event and checks the beats
    // that leave the block, oldest first.
    class dac_word_scoreboard;
        t_wave                  wave;
        logic [VELOCITY_W-1:0]  velocity;
        logic [SAMPLE_W-1:0]    ramp;
        logic [TABLE_IDX_W-1:0] sine_pos;
        logic [TABLE_IDX_W-1:0] tri_pos;
        t_dac_beat              pending_words[$];
        int unsigned            errors;
        int unsigned            ticks;
        int unsigned            duty_ends;
        int unsigned            beats_checked;

        function new();
            wave          = WAVE_SQUARE;
            velocity      = VELOCITY_RST;
            ramp          = '0;
            sine_pos      = '0;
            tri_pos       = '0;
            errors        = 0;
            ticks         = 0;
            duty_ends     = 0;
            beats_checked = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
            if (idx == CFG_WAVE_SELECT) begin
                wave = t_wave'(value[1:0]);
            end else begin
                velocity = value;
            end
        endfunction

        function void take_event(logic kind, logic [OFFSET_W-1:0] offset);
            logic [SAMPLE_W-1:0]  raw;
            logic [DIVISOR_W-1:0] divisor;
            logic [SAMPLE_W-1:0]  scaled;
            int                   climb;
            t_dac_beat            word;
            raw    = '0;
            scaled = '0;
            if (kind == EVT_SAMPLE) begin
                ticks++;
                // Only the counter of the selected wave moves.
                case (wave)
                    WAVE_SQUARE: begin
                        raw = FULL_SCALE;
                    end
                    WAVE_SAWTOOTH: begin
                        climb = int'(ramp) + RAMP_INC;
                        if (ramp == FULL_SCALE) begin
                            ramp = '0;
                        end else if (climb >= 4096) begin
                            ramp = FULL_SCALE;
                        end else begin
                            ramp = SAMPLE_W'(climb);
                        end
                        raw = ramp;
                    end
                    WAVE_SINE: begin
                        raw      = SINE_LUT[sine_pos];
                        sine_pos = sine_pos + 1'b1;
                    end
                    default: begin
                        raw     = TRI_LUT[tri_pos];
                        tri_pos = tri_pos + 1'b1;
                    end
                endcase
                divisor = {1'b0, velocity} + {1'b0, offset};
                // A zero divisor saturates the quotient.
                scaled = (divisor == '0) ? FULL_SCALE : SAMPLE_W'(raw / divisor);
            end else begin
                duty_ends++;
            end
            word.dac    = {DAC_CTRL, scaled};
            word.scaled = scaled;
            pending_words.push_back(word);
        endfunction

        function void check_dac_beat(logic [M_TDATA_W-1:0] tdata);
            t_dac_beat want;
            if (pending_words.size() == 0) begin
                $error("output beat with no event waiting: tdata 0x%08h", tdata);
                errors++;
                return;
            end
            want = pending_words.pop_front();
            beats_checked++;
            if (tdata[15:0] !== want.dac) begin
                $error("dac_word mismatch: expected 0x%04h, got 0x%04h", want.dac, tdata[15:0]);
                errors++;
            end
            if (tdata[27:16] !== want.scaled) begin
                $error("sample_value mismatch: expected %0d, got %0d",
                       want.scaled, tdata[27:16]);
                errors++;
            end
            if (tdata[31:28] !== 4'h0) begin
                $error("tdata padding mismatch: expected 0x0, got 0x%01h", tdata[31:28]);
                errors++;
            end
        endfunction
    endclass

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_cfg_we;
    logic [CFG_IDX_W-1:0]   i_cfg_addr;
    logic [CFG_DATA_W-1:0]  i_cfg_data;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [S_TDATA_W-1:0]   s_axis_tdata;   // [7:0] envelope_offset
    logic                   s_axis_tuser;   // [0] event_kind
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [M_TDATA_W-1:0]   m_axis_tdata;   // [15:0] dac_word, [27:16] sample_value

    dac_word_scoreboard sb;
    int unsigned        send_idle_pct;
    int unsigned        recv_stall_pct;

    waveform_sample_generator u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
    end

    always #(CLK_HALF) i_clk = ~i_clk;

    // The receiver stalls at random; the rate is set per phase.
    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99, 0) >= recv_stall_pct);
    end

    // Both handshakes are sampled at the clock edge, where the values seen
    // are still the ones that held before the edge.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                sb.take_event(s_axis_tuser, s_axis_tdata);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                sb.check_dac_beat(m_axis_tdata);
            end
        end
    end

    // Presents one event and returns at the edge where it is accepted. A gap
    // lowers tvalid at that same edge, so valid never drops and rises in one
    // step.
    task automatic send_event(input logic kind, input logic [OFFSET_W-1:0] offset);
        while ($urandom_range(99, 0) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= offset;
        do begin
            @(posedge i_clk);
        end while (!s_axis_tready);
    endtask

    // Holds the sender back until every outstanding beat has been checked.
    // Every event yields a beat, so an empty queue means the block is idle.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending_words.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // One register write; the predictor follows at the same moment.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_data <= value;
        sb.set_reg(idx, value);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // Safety net against a hung handshake.
    initial begin
        #5_000_000;
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        static int unsigned idle_plan  [RANDOM_PHASES] = '{0, 82, 0, 28};
        static int unsigned stall_plan [RANDOM_PHASES] = '{0, 0, 82, 28};
        int unsigned pick;
        logic [OFFSET_W-1:0]   offset;
        logic [CFG_DATA_W-1:0] velocity;

        sb             = new();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_addr    <= CFG_WAVE_SELECT;
        i_cfg_data    <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= EVT_SAMPLE;
        m_axis_tready <= 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part. Reset values first: square wave, divisor one, so
        // full scale with no offset and a small quotient with the largest.
        send_event(EVT_SAMPLE, 8'd0);
        send_event(EVT_SAMPLE, 8'd255);
        send_event(EVT_DUTY_END, 8'd255);
        drain();

        // Whole sawtooth climb: fifteen steps, saturation, then back to zero.
        write_reg(CFG_WAVE_SELECT, CFG_DATA_W'(WAVE_SAWTOOTH));
        repeat (17) send_event(EVT_SAMPLE, 8'd0);
        drain();

        // Zero divisor saturates the quotient; a duty end on the sine leaves
        // its position untouched.
        write_reg(CFG_WAVE_SELECT, CFG_DATA_W'(WAVE_SINE));
        write_reg(CFG_VELOCITY, 8'd0);
        send_event(EVT_SAMPLE, 8'd0);
        send_event(EVT_DUTY_END, 8'd0);
        send_event(EVT_SAMPLE, 8'd0);
        drain();

        // Largest divisor on the triangle.
        write_reg(CFG_WAVE_SELECT, CFG_DATA_W'(WAVE_TRIANGLE));
        write_reg(CFG_VELOCITY, 8'd255);
        send_event(EVT_SAMPLE, 8'd255);
        send_event(EVT_SAMPLE, 8'd255);
        drain();

        // Random part: four handshake regimes, each split into segments
        // with their own wave and divisor so the counters run long enough
        // to wrap while the setting changes often.
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            send_idle_pct  = idle_plan[phase];
            recv_stall_pct = stall_plan[phase];
            for (int seg = 0; seg < PHASE_EVENTS / SEGMENT_SIZE; seg++) begin
                drain();
                pick = $urandom_range(9, 0);
                case (pick)
                    0: velocity = 8'd0;
                    1: velocity = 8'd1;
                    2: velocity = 8'd255;
                    default: velocity = CFG_DATA_W'($urandom_range(255, 0));
                endcase
                write_reg(CFG_WAVE_SELECT, CFG_DATA_W'($urandom_range(3, 0)));
                write_reg(CFG_VELOCITY, velocity);
                for (int n = 0; n < SEGMENT_SIZE; n++) begin
                    pick = $urandom_range(9, 0);
                    case (pick)
                        0: offset = 8'd0;
                        1: offset = 8'd255;
                        default: offset = OFFSET_W'($urandom_range(255, 0));
                    endcase
                    send_event(($urandom_range(3, 0) == 0) ? EVT_DUTY_END : EVT_SAMPLE,
                               offset);
                end
            end
        end

        drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Covered %0d sample ticks and %0d duty ends over all four waves,",
                 sb.ticks, sb.duty_ends);
        $display("with %0d DAC beats checked under free, sender, receiver and mixed stalls.",
                 sb.beats_checked);
        if (sb.errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
